[rtl/core/slcfr_pkg.sv]
`default_nettype none

package slcfr_pkg;

   localparam int unsigned StoreDepth  = 64;
   localparam int unsigned StoreAddrW  = $clog2(StoreDepth);
   localparam int unsigned LenW        = 6;

   localparam logic [7:0]  MinFrameLen = 8'd2;
   localparam logic [7:0]  MaxFrameLen = 8'd62;
   localparam logic [7:0]  CrcPoly     = 8'hD5;

   localparam logic [7:0]  SyncByteRst    = 8'd200;
   localparam logic [7:0]  IdleTimeoutRst = 8'd10;
   localparam logic [7:0]  IdleMsMax      = 8'd255;

   localparam logic        ReqByte = 1'b0;
   localparam logic        ReqTick = 1'b1;

   localparam logic        CsrSyncByte    = 1'b0;
   localparam logic        CsrIdleTimeout = 1'b1;

   // CRC-8, MSB first, no reflection, no final xor
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/core/sync_length_crc8_frame_receiver.sv]
`default_nettype none

// Frame receiver for sync/length/CRC-8 framed serial data. Each req transfer
// is either a received byte or a one-millisecond tick (tuser). After the last
// byte of a frame whose CRC matches, the block emits the type byte and the
// payload bytes from its 64-entry frame store; each result goes through a
// store read, then an output register load, and req is blocked for the whole
// emission, rsp stalls included. Frames with a bad CRC are dropped with no
// output. The rsp output register lets the next req transfer be taken while
// the final result waits.
module sync_length_crc8_frame_receiver
   import slcfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] req_type

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [7:0] out_byte, [13:8] payload_length, [15:14] zero
   output logic             rsp_tuser,   // [0] is_frame_type
   output logic             rsp_tlast,   // last_of_frame

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);

   typedef enum logic [4:0] {
      ST_HUNT = 5'b00001,
      ST_LEN  = 5'b00010,
      ST_TAKE = 5'b00100,
      ST_READ = 5'b01000,
      ST_LOAD = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [7:0]          sync_byte_ff, sync_byte_in;
   logic [7:0]          idle_timeout_ff, idle_timeout_in;
   logic [LenW-1:0]     bytes_taken_ff, bytes_taken_in;
   logic [LenW-1:0]     frame_length_ff, frame_length_in;
   logic [7:0]          crc_ff, crc_in;
   logic [7:0]          idle_ms_ff, idle_ms_in;
   logic [LenW-1:0]     plen_ff, plen_in;
   logic [LenW-1:0]     emit_cnt_ff, emit_cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic [LenW-1:0]     rsp_len_ff, rsp_len_in;
   logic                rsp_type_ff, rsp_type_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_xfer;
   logic                csr_xfer;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [7:0]          ram_rd_data;
   logic [7:0]          idle_inc;
   logic                load_ok;

   assign req_tready = (state_ff == ST_HUNT) || (state_ff == ST_LEN) || (state_ff == ST_TAKE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_xfer   = csr_valid && csr_ready;
   assign idle_inc   = (idle_ms_ff == IdleMsMax) ? idle_ms_ff : idle_ms_ff + 8'd1;
   assign load_ok    = !rsp_valid_ff || rsp_tready;
   assign ram_wr_en  = req_xfer && (req_tuser == ReqByte) && (state_ff == ST_TAKE);
   assign ram_rd_en  = (state_ff == ST_READ);

   slcfr_ram #(
      .WIDTH (8),
      .DEPTH (StoreDepth)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (bytes_taken_ff[StoreAddrW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (ram_rd_en),
      .rd_addr (emit_cnt_ff[StoreAddrW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      sync_byte_in    = sync_byte_ff;
      idle_timeout_in = idle_timeout_ff;
      if (csr_xfer) begin
         unique case (csr_index)
            CsrSyncByte:    sync_byte_in    = csr_data;
            CsrIdleTimeout: idle_timeout_in = csr_data;
            default:        ;
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      bytes_taken_in  = bytes_taken_ff;
      frame_length_in = frame_length_ff;
      crc_in          = crc_ff;
      idle_ms_in      = idle_ms_ff;
      plen_in         = plen_ff;
      emit_cnt_in     = emit_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_byte_in     = rsp_byte_ff;
      rsp_len_in      = rsp_len_ff;
      rsp_type_in     = rsp_type_ff;
      rsp_last_in     = rsp_last_ff;

      if (req_xfer && (req_tuser == ReqTick)) begin
         idle_ms_in = idle_inc;
         if ((state_ff != ST_HUNT) && (idle_inc > idle_timeout_ff)) begin
            state_in = ST_HUNT;
         end
      end else if (req_xfer) begin
         idle_ms_in = '0;
         unique case (state_ff)
            ST_LEN: begin
               if ((req_tdata >= MinFrameLen) && (req_tdata <= MaxFrameLen)) begin
                  frame_length_in = req_tdata[LenW-1:0];
                  bytes_taken_in  = '0;
                  crc_in          = '0;
                  state_in        = ST_TAKE;
               end
            end
            ST_TAKE: begin
               bytes_taken_in = bytes_taken_ff + 1'b1;
               if ({1'b0, bytes_taken_ff} + 7'd1 < {1'b0, frame_length_ff}) begin
                  crc_in = crc8_step(crc_ff, req_tdata);
               end else if (req_tdata == crc_ff) begin
                  plen_in     = frame_length_ff - LenW'(2);
                  emit_cnt_in = '0;
                  state_in    = ST_READ;
               end else begin
                  state_in = ST_HUNT;
               end
            end
            default: begin
               state_in = (req_tdata == sync_byte_ff) ? ST_LEN : ST_HUNT;
            end
         endcase
      end

      if (state_ff == ST_READ) begin
         state_in = ST_LOAD;
      end else if ((state_ff == ST_LOAD) && load_ok) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = ram_rd_data;
         rsp_len_in   = plen_ff;
         rsp_type_in  = (emit_cnt_ff == '0);
         rsp_last_in  = (emit_cnt_ff == plen_ff);
         emit_cnt_in  = emit_cnt_ff + 1'b1;
         state_in     = (emit_cnt_ff == plen_ff) ? ST_HUNT : ST_READ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_HUNT;
         sync_byte_ff    <= SyncByteRst;
         idle_timeout_ff <= IdleTimeoutRst;
         bytes_taken_ff  <= '0;
         frame_length_ff <= '0;
         crc_ff          <= '0;
         idle_ms_ff      <= '0;
         plen_ff         <= '0;
         emit_cnt_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sync_byte_ff    <= sync_byte_in;
         idle_timeout_ff <= idle_timeout_in;
         bytes_taken_ff  <= bytes_taken_in;
         frame_length_ff <= frame_length_in;
         crc_ff          <= crc_in;
         idle_ms_ff      <= idle_ms_in;
         plen_ff         <= plen_in;
         emit_cnt_ff     <= emit_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_type_ff <= rsp_type_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_len_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_type_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOAD))
      else $error("result appeared without a store load");

   a_take_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAKE) |-> (bytes_taken_ff < frame_length_ff) &&
                                ({2'b00, frame_length_ff} >= MinFrameLen) &&
                                ({2'b00, frame_length_ff} <= MaxFrameLen))
      else $error("byte position or frame length out of range");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_LOAD)) |-> (emit_cnt_ff <= plen_ff))
      else $error("emit count beyond payload length");

   a_no_req_in_emit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_LOAD)) |-> !req_tready)
      else $error("input taken during emission");

endmodule

`default_nettype wire

[rtl/core/slcfr_ram.sv]
`default_nettype none

module slcfr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
